// ===== src/hslc_pkg.sv =====
// ----------------------------------------------------------------------------
// hslc_pkg
// Shared types and constants of the HSL colorize pixel pipeline.
// ----------------------------------------------------------------------------
package hslc_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int CHAN_W = 8;
	localparam int HUE_W  = 9;
	localparam int SATP_W = 7;
	localparam int LUMP_W = 8;
	localparam int WGT_W  = 6;
	localparam int NUM_CH = 3;

	// lane order
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	localparam logic [LUMP_W-1:0] LUM_PCT_UNITY = 8'd100;
	localparam logic [SATP_W-1:0] SAT_PCT_MAX   = 7'd100;

	typedef enum logic [1:0] {
		REG_HUE_SHIFT = 2'd0,
		REG_SAT_PCT   = 2'd1,
		REG_LUM_PCT   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [LUMP_W-1:0]             lum_pct;
		logic [SATP_W-1:0]             sat_pct;
		logic [NUM_CH-1:0][WGT_W-1:0]  wgt;
	} cfg_t;

endpackage

// ===== src/hslc_cfg.sv =====
// ----------------------------------------------------------------------------
// hslc_cfg
// Register file on the APB port, plus the per-channel hue weights and the
// clamped saturation that the pipeline reads.
// ----------------------------------------------------------------------------
module hslc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hslc_pkg::ADDR_W-1:0]   paddr,
	input  logic [hslc_pkg::DATA_W-1:0]   pwdata,
	output logic [hslc_pkg::DATA_W-1:0]   prdata,
	output hslc_pkg::cfg_t                cfg
);
	import hslc_pkg::*;

	logic [HUE_W-1:0]  hue_shift_q;
	logic [SATP_W-1:0] sat_pct_q;
	logic [LUMP_W-1:0] lum_pct_q;
	cfg_t              cfg_q;

	logic              wr_en;
	logic [1:0]        reg_idx;
	logic [9:0]        hue_t1;
	logic [9:0]        hue_t2;
	logic [HUE_W-1:0]  hue_green;
	logic [9:0]        hue_r10;
	logic [9:0]        hue_b10;
	logic [HUE_W-1:0]  hue_red;
	logic [HUE_W-1:0]  hue_blue;
	cfg_t              cfg_d;

	function automatic logic [WGT_W-1:0] hue_weight(input logic [HUE_W-1:0] h);
		logic [WGT_W-1:0] w;
		if (h < 9'd60) begin
			w = h[WGT_W-1:0];
		end else if (h < 9'd180) begin
			w = 6'd60;
		end else if (h < 9'd240) begin
			w = WGT_W'(9'd240 - h);
		end else begin
			w = '0;
		end
		return w;
	endfunction

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_shift_q <= '0;
			sat_pct_q   <= '0;
			lum_pct_q   <= LUM_PCT_UNITY;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HUE_SHIFT: begin
					hue_shift_q <= pwdata[HUE_W-1:0];
				end
				REG_SAT_PCT: begin
					sat_pct_q <= pwdata[SATP_W-1:0];
				end
				REG_LUM_PCT: begin
					lum_pct_q <= pwdata[LUMP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HUE_SHIFT: prdata = DATA_W'(hue_shift_q);
			REG_SAT_PCT:   prdata = DATA_W'(sat_pct_q);
			REG_LUM_PCT:   prdata = DATA_W'(lum_pct_q);
			default:       prdata = '0;
		endcase
	end

	// target hue is (720 - shift) mod 360
	always_comb begin
		hue_t1    = 10'd720 - 10'(hue_shift_q);
		hue_t2    = (hue_t1 >= 10'd360) ? (hue_t1 - 10'd360) : hue_t1;
		hue_green = (hue_t2 >= 10'd360) ? HUE_W'(hue_t2 - 10'd360) : HUE_W'(hue_t2);
		hue_r10   = 10'(hue_green) + 10'd120;
		hue_b10   = 10'(hue_green) + 10'd240;
		hue_red   = (hue_r10 >= 10'd360) ? HUE_W'(hue_r10 - 10'd360) : HUE_W'(hue_r10);
		hue_blue  = (hue_b10 >= 10'd360) ? HUE_W'(hue_b10 - 10'd360) : HUE_W'(hue_b10);

		cfg_d.lum_pct       = lum_pct_q;
		cfg_d.sat_pct       = (sat_pct_q > SAT_PCT_MAX) ? SAT_PCT_MAX : sat_pct_q;
		cfg_d.wgt[CH_RED]   = hue_weight(hue_red);
		cfg_d.wgt[CH_GREEN] = hue_weight(hue_green);
		cfg_d.wgt[CH_BLUE]  = hue_weight(hue_blue);
	end

	always_ff @(posedge clk) begin
		cfg_q <= cfg_d;
	end

	assign cfg = cfg_q;

endmodule

// ===== src/hsl_colorize_pixel.sv =====
// ----------------------------------------------------------------------------
// hsl_colorize_pixel
// Colorizes one RGB pixel per item: keeps its lightness, applies the
// configured hue, saturation and lightness adjust, converts back to RGB.
// ----------------------------------------------------------------------------
// throughput: one item per clock while out_ready holds, ten register stages each with its own valid
// a stalled output holds only the stages behind it that are full
// reset clears all stage valids; hue_shift and saturation_percent reset to 0,
// lum_percent to 100
module hsl_colorize_pixel #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hslc_pkg::CHAN_W-1:0]   red_in,
	input  logic [hslc_pkg::CHAN_W-1:0]   green_in,
	input  logic [hslc_pkg::CHAN_W-1:0]   blue_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hslc_pkg::CHAN_W-1:0]   red_out,
	output logic [hslc_pkg::CHAN_W-1:0]   green_out,
	output logic [hslc_pkg::CHAN_W-1:0]   blue_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hslc_pkg::ADDR_W-1:0]   paddr,
	input  logic [hslc_pkg::DATA_W-1:0]   pwdata,
	output logic [hslc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import hslc_pkg::*;

	localparam int LW      = FRAC_BITS + 1;
	localparam int L0P_W   = FRAC_BITS + 19;
	localparam int M510_W  = FRAC_BITS + 10;
	localparam int SATM_W  = FRAC_BITS + 8;
	localparam int SATP_PW = FRAC_BITS + 15;
	localparam int Y_W     = FRAC_BITS + 8;
	localparam int YP_W    = FRAC_BITS + 9;
	localparam int M100_W  = FRAC_BITS + 9;
	localparam int YQ_W    = 2 * FRAC_BITS + 17;
	localparam int LQ_W    = FRAC_BITS + 2;
	localparam int LS_W    = FRAC_BITS + 3;
	localparam int PP_W    = 2 * FRAC_BITS + 2;
	localparam int MW      = FRAC_BITS + 2;
	localparam int DW_W    = FRAC_BITS + 6;
	localparam int DWP_W   = FRAC_BITS + 7;
	localparam int M60_W   = FRAC_BITS + 7;
	localparam int DQ_W    = 2 * FRAC_BITS + 13;
	localparam int C_W     = FRAC_BITS + 10;

	localparam logic [LW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [LW-1:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

	// reciprocals rounded up, exact over the operand ranges used
	localparam logic [63:0] M510_FULL  = ((64'd1 << (FRAC_BITS + 18)) + 64'd509) / 64'd510;
	localparam logic [63:0] M100S_FULL = ((64'd1 << (FRAC_BITS + 14)) + 64'd99) / 64'd100;
	localparam logic [63:0] M100_FULL  = ((64'd1 << (FRAC_BITS + 15)) + 64'd99) / 64'd100;
	localparam logic [63:0] M60_FULL   = ((64'd1 << (FRAC_BITS + 12)) + 64'd59) / 64'd60;
	localparam logic [M510_W-1:0] M510  = M510_FULL[M510_W-1:0];
	localparam logic [SATM_W-1:0] M100S = M100S_FULL[SATM_W-1:0];
	localparam logic [M100_W-1:0] M100  = M100_FULL[M100_W-1:0];
	localparam logic [M60_W-1:0]  M60   = M60_FULL[M60_W-1:0];

	cfg_t               cfg;
	logic [SATP_PW-1:0] sat_prod;
	logic [LW-1:0]      sat_q;

	// stage valids and enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic en_s6, en_s7, en_s8, en_s9, en_s10;

	// datapath
	logic [CHAN_W-1:0]  mx, mn;
	logic [8:0]         sum_s1;
	logic [L0P_W-1:0]   l0prod_s2;
	logic [LW-1:0]      l0;
	logic               hi;
	logic [LW-1:0]      mul_a;
	logic [LUMP_W-1:0]  mul_b;
	logic [YP_W-1:0]    ymul;
	logic [Y_W-1:0]     y_s3;
	logic [LW-1:0]      l0_s3;
	logic               hi_s3;
	logic [YQ_W-1:0]    yq_s4;
	logic [LW-1:0]      l0_s4;
	logic               hi_s4;
	logic [LQ_W-1:0]    lq;
	logic [LS_W-1:0]    lsum;
	logic [LW-1:0]      lum;
	logic [LW-1:0]      lum_s5;
	logic [PP_W-1:0]    pprod_s6;
	logic [LW-1:0]      lum_s6;
	logic [LW-1:0]      pval;
	logic [MW-1:0]      m2w, m1w, dw;
	logic [LW-1:0]      m1_s7, d_s7;
	logic [LW-1:0]      m1_s8, m1_s9;
	logic [DWP_W-1:0]   dwprod  [NUM_CH];
	logic [DW_W-1:0]    dw_s8   [NUM_CH];
	logic [DQ_W-1:0]    dq_s9   [NUM_CH];
	logic [LW-1:0]      frac    [NUM_CH];
	logic [MW-1:0]      vch     [NUM_CH];
	logic [C_W-1:0]     c255    [NUM_CH];
	logic [9:0]         chw     [NUM_CH];
	logic [CHAN_W-1:0]  chan    [NUM_CH];
	logic [CHAN_W-1:0]  chan_s10[NUM_CH];

	hslc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// saturation as a fraction of one
	assign sat_prod = SATP_PW'(cfg.sat_pct) * SATP_PW'(M100S);

	always_ff @(posedge clk) begin
		sat_q <= sat_prod[14 +: LW];
	end

	// flow control
	assign en_s10   = !vld_s10 || out_ready;
	assign en_s9    = !vld_s9  || en_s10;
	assign en_s8    = !vld_s8  || en_s9;
	assign en_s7    = !vld_s7  || en_s8;
	assign en_s6    = !vld_s6  || en_s7;
	assign en_s5    = !vld_s5  || en_s6;
	assign en_s4    = !vld_s4  || en_s5;
	assign en_s3    = !vld_s3  || en_s4;
	assign en_s2    = !vld_s2  || en_s3;
	assign en_s1    = !vld_s1  || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			if (en_s1)  vld_s1  <= in_valid;
			if (en_s2)  vld_s2  <= vld_s1;
			if (en_s3)  vld_s3  <= vld_s2;
			if (en_s4)  vld_s4  <= vld_s3;
			if (en_s5)  vld_s5  <= vld_s4;
			if (en_s6)  vld_s6  <= vld_s5;
			if (en_s7)  vld_s7  <= vld_s6;
			if (en_s8)  vld_s8  <= vld_s7;
			if (en_s9)  vld_s9  <= vld_s8;
			if (en_s10) vld_s10 <= vld_s9;
		end
	end

	// max + min of the pixel
	always_comb begin
		mx = red_in;
		mn = red_in;
		if (green_in > mx) mx = green_in;
		if (blue_in > mx)  mx = blue_in;
		if (green_in < mn) mn = green_in;
		if (blue_in < mn)  mn = blue_in;
	end

	// lightness adjust operands
	always_comb begin
		l0    = l0prod_s2[18 +: LW];
		hi    = cfg.lum_pct > LUM_PCT_UNITY;
		mul_a = hi ? (ONE - l0) : l0;
		mul_b = hi ? (cfg.lum_pct - LUM_PCT_UNITY) : cfg.lum_pct;
		ymul  = YP_W'(mul_a) * YP_W'(mul_b);
	end

	always_comb begin
		lq   = yq_s4[FRAC_BITS + 15 +: LQ_W];
		lsum = LS_W'(l0_s4) + LS_W'(lq);
		if (hi_s4) begin
			lum = (lsum > LS_W'(ONE)) ? ONE : lsum[LW-1:0];
		end else begin
			lum = lq[LW-1:0];
		end
	end

	// m1 and m2 of the hsl conversion
	always_comb begin
		pval = pprod_s6[FRAC_BITS +: LW];
		if (lum_s6 <= HALF) begin
			m2w = MW'(lum_s6) + MW'(pval);
		end else begin
			m2w = MW'(lum_s6) + MW'(sat_q) - MW'(pval);
		end
		m1w = {lum_s6, 1'b0} - m2w;
		dw  = m2w - m1w;
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			dwprod[c] = DWP_W'(d_s7) * DWP_W'(cfg.wgt[c]);
			frac[c]   = dq_s9[c][FRAC_BITS + 12 +: LW];
			vch[c]    = MW'(m1_s9) + MW'(frac[c]);
			c255[c]   = (C_W'(vch[c]) << 8) - C_W'(vch[c]);
			chw[c]    = c255[c][FRAC_BITS +: 10];
			chan[c]   = (chw[c] > 10'd255) ? 8'hFF : chw[c][CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sum_s1 <= 9'(mx) + 9'(mn);
		end
		if (en_s2) begin
			l0prod_s2 <= L0P_W'(sum_s1) * L0P_W'(M510);
		end
		if (en_s3) begin
			y_s3  <= ymul[Y_W-1:0];
			l0_s3 <= l0;
			hi_s3 <= hi;
		end
		if (en_s4) begin
			yq_s4 <= YQ_W'(y_s3) * YQ_W'(M100);
			l0_s4 <= l0_s3;
			hi_s4 <= hi_s3;
		end
		if (en_s5) begin
			lum_s5 <= lum;
		end
		if (en_s6) begin
			pprod_s6 <= PP_W'(lum_s5) * PP_W'(sat_q);
			lum_s6   <= lum_s5;
		end
		if (en_s7) begin
			m1_s7 <= m1w[LW-1:0];
			d_s7  <= dw[LW-1:0];
		end
		if (en_s8) begin
			for (int c = 0; c < NUM_CH; c++) begin
				dw_s8[c] <= dwprod[c][DW_W-1:0];
			end
			m1_s8 <= m1_s7;
		end
		if (en_s9) begin
			for (int c = 0; c < NUM_CH; c++) begin
				dq_s9[c] <= DQ_W'(dw_s8[c]) * DQ_W'(M60);
			end
			m1_s9 <= m1_s8;
		end
		if (en_s10) begin
			for (int c = 0; c < NUM_CH; c++) begin
				chan_s10[c] <= chan[c];
			end
		end
	end

	assign out_valid = vld_s10;
	assign red_out   = chan_s10[CH_RED];
	assign green_out = chan_s10[CH_GREEN];
	assign blue_out  = chan_s10[CH_BLUE];

endmodule
